// File: design/cfb_pkg.sv
`default_nettype none

package cfb_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_BYTE    = 3'd0;
    localparam logic [2:0] CFG_END_BYTE      = 3'd1;
    localparam logic [2:0] CFG_ACTIVITY_MASK = 3'd2;
    localparam logic [2:0] CFG_RESPONSE_MASK = 3'd3;
    localparam logic [2:0] CFG_TARGET_MASK   = 3'd4;
    localparam logic [2:0] CFG_SOURCE_MASK   = 3'd5;

    // Input item kinds
    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // Job queue between front and back end
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [7:0] SUM_INVERT = 8'hFF;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] activity_mask;
        logic [7:0] response_mask;
        logic [7:0] target_mask;
        logic [7:0] source_mask;
    } cfg_t;

    // One classified job: a header or a payload byte
    typedef struct packed {
        logic       is_header;
        logic       close;      // checksum and end byte follow
        logic [7:0] flags;
        logic [7:0] target_id;
        logic [7:0] source_id;
        logic [7:0] device_id;
        logic [7:0] command_id;
        logic [7:0] seq;
        logic [7:0] data_byte;
    } job_t;

    // Head of the job queue as seen by the back end
    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    typedef enum logic [3:0] {
        ST_BEGIN,
        ST_START,
        ST_FLAGS,
        ST_TGT,
        ST_SRC,
        ST_DEV,
        ST_CMD,
        ST_SEQ,
        ST_DATA,
        ST_CHK,
        ST_END
    } step_t;

endpackage

`default_nettype wire

// File: design/cfb_front.sv
`default_nettype none

module cfb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfb_pkg::cfg_t cfg,
    input  wire logic          accept,
    input  wire logic          cmd,
    input  wire logic [7:0]    command_id,
    input  wire logic [7:0]    device_id,
    input  wire logic [7:0]    source_id,
    input  wire logic [7:0]    target_id,
    input  wire logic [7:0]    payload_count,
    input  wire logic          want_response,
    input  wire logic [7:0]    data_byte,
    output logic               push,
    output cfb_pkg::job_t      job
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] seq_reg, seq_next;
    logic [7:0] flags;

    // Flags byte of a header
    always_comb
    begin
        flags = cfg.activity_mask;
        if (want_response)
        begin
            flags = flags | cfg.response_mask;
        end
        if (target_id != 8'd0)
        begin
            flags = flags | cfg.target_mask;
        end
        if (source_id != 8'd0)
        begin
            flags = flags | cfg.source_mask;
        end
    end

    // Classify the word and track frame state
    always_comb
    begin
        in_frame_next = in_frame_reg;
        left_next     = left_reg;
        seq_next      = seq_reg;
        push          = 1'b0;

        job.is_header  = (cmd == cfb_pkg::CMD_HEADER);
        job.close      = 1'b0;
        job.flags      = flags;
        job.target_id  = target_id;
        job.source_id  = source_id;
        job.device_id  = device_id;
        job.command_id = command_id;
        job.seq        = seq_reg;
        job.data_byte  = data_byte;

        if (accept)
        begin
            if (cmd == cfb_pkg::CMD_HEADER)
            begin
                if (!in_frame_reg)
                begin
                    push     = 1'b1;
                    seq_next = seq_reg + 8'd1;
                    if (payload_count == 8'd0)
                    begin
                        job.close = 1'b1;
                    end
                    else
                    begin
                        in_frame_next = 1'b1;
                        left_next     = payload_count;
                    end
                end
            end
            else
            begin
                if (in_frame_reg)
                begin
                    push      = 1'b1;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        job.close     = 1'b1;
                        in_frame_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            left_reg     <= 8'd0;
            seq_reg      <= 8'd1;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            left_reg     <= left_next;
            seq_reg      <= seq_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cfb_queue.sv
`default_nettype none

module cfb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire cfb_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output cfb_pkg::head_t     head
);

    localparam int AW = cfb_pkg::QUEUE_AW;

    cfb_pkg::job_t mem_reg [cfb_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full       = (count_reg == (AW+1)'(cfb_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: design/cfb_back.sv
`default_nettype none

module cfb_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cfb_pkg::cfg_t  cfg,
    input  wire cfb_pkg::head_t head,
    output logic                pop,
    output logic                line_valid,
    input  wire logic           line_ready,
    output logic [7:0]          line_byte,
    output logic                run_last,
    output logic                frame_end
);

    cfb_pkg::step_t step_reg, step_next, cur_step, after_step;
    logic [7:0]     sum_reg, sum_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic           fin_reg, fin_next;
    logic           advance;
    logic           body;
    logic           done;
    logic           has_tgt, has_src;

    assign has_tgt = (head.job.target_id != 8'd0);
    assign has_src = (head.job.source_id != 8'd0);
    assign advance = head.valid && (!out_valid_reg || line_ready);
    assign pop     = advance && done;

    // Resolve the opening step of a fresh job
    always_comb
    begin
        if (step_reg == cfb_pkg::ST_BEGIN)
        begin
            cur_step = head.job.is_header ? cfb_pkg::ST_START : cfb_pkg::ST_DATA;
        end
        else
        begin
            cur_step = step_reg;
        end
    end

    // Next step
    always_comb
    begin
        case (cur_step)
            cfb_pkg::ST_START: after_step = cfb_pkg::ST_FLAGS;
            cfb_pkg::ST_FLAGS:
            begin
                if (has_tgt)
                begin
                    after_step = cfb_pkg::ST_TGT;
                end
                else if (has_src)
                begin
                    after_step = cfb_pkg::ST_SRC;
                end
                else
                begin
                    after_step = cfb_pkg::ST_DEV;
                end
            end
            cfb_pkg::ST_TGT: after_step = has_src ? cfb_pkg::ST_SRC : cfb_pkg::ST_DEV;
            cfb_pkg::ST_SRC: after_step = cfb_pkg::ST_DEV;
            cfb_pkg::ST_DEV: after_step = cfb_pkg::ST_CMD;
            cfb_pkg::ST_CMD: after_step = cfb_pkg::ST_SEQ;
            cfb_pkg::ST_SEQ,
            cfb_pkg::ST_DATA:
                after_step = head.job.close ? cfb_pkg::ST_CHK : cfb_pkg::ST_BEGIN;
            cfb_pkg::ST_CHK: after_step = cfb_pkg::ST_END;
            default:         after_step = cfb_pkg::ST_BEGIN;
        endcase
        step_next = advance ? after_step : step_reg;
    end

    // Byte and marks for the current step
    always_comb
    begin
        byte_next = head.job.data_byte;
        last_next = 1'b0;
        fin_next  = 1'b0;
        body      = 1'b1;
        done      = 1'b0;
        case (cur_step)
            cfb_pkg::ST_START:
            begin
                byte_next = cfg.start_byte;
                body      = 1'b0;
            end
            cfb_pkg::ST_FLAGS: byte_next = head.job.flags;
            cfb_pkg::ST_TGT:   byte_next = head.job.target_id;
            cfb_pkg::ST_SRC:   byte_next = head.job.source_id;
            cfb_pkg::ST_DEV:   byte_next = head.job.device_id;
            cfb_pkg::ST_CMD:   byte_next = head.job.command_id;
            cfb_pkg::ST_SEQ:
            begin
                byte_next = head.job.seq;
                last_next = !head.job.close;
                done      = !head.job.close;
            end
            cfb_pkg::ST_DATA:
            begin
                byte_next = head.job.data_byte;
                last_next = !head.job.close;
                done      = !head.job.close;
            end
            cfb_pkg::ST_CHK:
            begin
                byte_next = sum_reg ^ cfb_pkg::SUM_INVERT;
                body      = 1'b0;
            end
            cfb_pkg::ST_END:
            begin
                byte_next = cfg.end_byte;
                last_next = 1'b1;
                fin_next  = 1'b1;
                body      = 1'b0;
                done      = 1'b1;
            end
            default:
            begin
                body = 1'b0;
            end
        endcase
    end

    // Running checksum
    always_comb
    begin
        sum_next = sum_reg;
        if (advance)
        begin
            if (cur_step == cfb_pkg::ST_START)
            begin
                sum_next = 8'd0;
            end
            else if (body)
            begin
                sum_next = sum_reg + byte_next;
            end
        end
    end

    // Output register valid
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (line_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= cfb_pkg::ST_BEGIN;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            fin_reg  <= fin_next;
        end
    end

    assign line_valid = out_valid_reg;
    assign line_byte  = byte_reg;
    assign run_last   = last_reg;
    assign frame_end  = fin_reg;

endmodule

`default_nettype wire

// File: design/command_frame_builder.sv
// Command frame builder: turns header and payload words into a framed byte stream.
// Input channel (item_valid/item_ready): cmd selects a header, which opens a frame,
// or a payload word carrying data_byte. Out-of-order words are taken and dropped.
// Output channel (line_valid/line_ready): the frame bytes in order, with run_last on
// the last byte an input word causes and frame_end on the closing end byte.
// Configuration: cfg_we writes cfg_data into register cfg_index (start byte, end
// byte, then the activity, response, target and source flag masks); write only
// while the block is idle.
// With the queue empty, an accepted word is first written into the job queue and
// its first byte is then loaded into the output register.
// A payload word sends its data byte, plus checksum and end byte if it closes the
// frame; a header sends start, flags, nonzero target and source IDs, device, command
// and sequence bytes, plus checksum and end byte if its payload count is zero; one
// byte a cycle while line_ready allows. A four-entry job queue from classifier to
// sequencer takes words while bytes are sent; item_ready drops only when it is full.
// When line_ready is low the held byte stays on the port and the sequencer waits;
// input words keep flowing until the queue fills.
// Reset clears the queue, the output register and the frame state, sets the
// sequence number to 1 and loads the register defaults.
`default_nettype none

module command_frame_builder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic       cmd,
    input  wire logic [7:0] command_id,
    input  wire logic [7:0] device_id,
    input  wire logic [7:0] source_id,
    input  wire logic [7:0] target_id,
    input  wire logic [7:0] payload_count,
    input  wire logic       want_response,
    input  wire logic [7:0] data_byte,
    output logic            line_valid,
    input  wire logic       line_ready,
    output logic [7:0]      line_byte,
    output logic            run_last,
    output logic            frame_end
);

    cfb_pkg::cfg_t  cfg_reg;
    cfb_pkg::job_t  job;
    cfb_pkg::head_t head;
    logic           push;
    logic           pop;
    logic           full;

    assign item_ready = !full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= 8'd141;
            cfg_reg.end_byte      <= 8'd216;
            cfg_reg.activity_mask <= 8'd8;
            cfg_reg.response_mask <= 8'd2;
            cfg_reg.target_mask   <= 8'd16;
            cfg_reg.source_mask   <= 8'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfb_pkg::CFG_START_BYTE:    cfg_reg.start_byte    <= cfg_data;
                cfb_pkg::CFG_END_BYTE:      cfg_reg.end_byte      <= cfg_data;
                cfb_pkg::CFG_ACTIVITY_MASK: cfg_reg.activity_mask <= cfg_data;
                cfb_pkg::CFG_RESPONSE_MASK: cfg_reg.response_mask <= cfg_data;
                cfb_pkg::CFG_TARGET_MASK:   cfg_reg.target_mask   <= cfg_data;
                cfb_pkg::CFG_SOURCE_MASK:   cfg_reg.source_mask   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    cfb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .accept        (item_valid && item_ready),
        .cmd           (cmd),
        .command_id    (command_id),
        .device_id     (device_id),
        .source_id     (source_id),
        .target_id     (target_id),
        .payload_count (payload_count),
        .want_response (want_response),
        .data_byte     (data_byte),
        .push          (push),
        .job           (job)
    );

    cfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .full     (full),
        .pop      (pop),
        .head     (head)
    );

    cfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .pop        (pop),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_byte  (line_byte),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire
